// File: rtl/sppd_pkg.sv
// Package for the siren pulse pattern decoder.
// Holds the register reset values, the decision and state codes and the structs
// passed between the top level and the decoder core. No dependencies.
package sppd_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_WIDTH      = 32;
    localparam int CFG_WIDTH      = 24;
    localparam int DEB_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [CFG_WIDTH-1:0] PULSE_MIN_RST    = 24'd120;
    localparam logic [CFG_WIDTH-1:0] PULSE_WINDOW_RST = 24'd2500;
    localparam logic [CFG_WIDTH-1:0] TRIGGER_RST      = 24'd30000;
    localparam logic [DEB_WIDTH-1:0] DEBOUNCE_RST     = 16'd25;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_PULSE_MIN    = 2'd0,
        CFG_PULSE_WINDOW = 2'd1,
        CFG_TRIGGER      = 2'd2,
        CFG_DEBOUNCE     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        DEC_NONE      = 2'd0,
        DEC_ARMED     = 2'd1,
        DEC_DISARMED  = 2'd2,
        DEC_TRIGGERED = 2'd3
    } t_decision;

    typedef enum logic [1:0] {
        ST_UNKNOWN   = 2'd0,
        ST_ARMED     = 2'd1,
        ST_DISARMED  = 2'd2,
        ST_TRIGGERED = 2'd3
    } t_state;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] pulse_min_ms;
        logic [CFG_WIDTH-1:0] pulse_window_ms;
        logic [CFG_WIDTH-1:0] trigger_ms;
        logic [DEB_WIDTH-1:0] hold_ms;
    } t_cfg;

    typedef struct packed {
        t_decision decision;
        logic      state_changed;
        t_state    reported_state;
    } t_result;

endpackage

// File: rtl/sppd_core.sv
// Decoder core: debounce, pulse timing, window counting and alarm decisions.
// Holds all decoder state and produces the result of the current sample.
// Depends on sppd_pkg.
module sppd_core #(
    parameter int TIME_WIDTH = sppd_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_sense_high,
    input  logic [sppd_pkg::NOW_WIDTH-1:0]    i_now_ms,
    input  sppd_pkg::t_cfg                    i_cfg,
    output sppd_pkg::t_result                 o_result
);
    import sppd_pkg::*;

    localparam int NW = (TIME_WIDTH < NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;
    localparam int CW = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

    logic                  r_raw, n_raw;
    logic                  r_stable, n_stable;
    logic [TIME_WIDTH-1:0] r_raw_time, n_raw_time;
    logic [TIME_WIDTH-1:0] r_pulse_start, n_pulse_start;
    logic [TIME_WIDTH-1:0] r_window_start, n_window_start;
    logic                  r_in_pulse, n_in_pulse;
    logic                  r_window_open, n_window_open;
    logic [1:0]            r_count, n_count;
    logic                  r_alarm, n_alarm;
    t_state                r_state, n_state;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] el_raw;
    logic [TIME_WIDTH-1:0] el_pulse;
    logic [TIME_WIDTH-1:0] el_window;
    logic                  pulse_set_now;
    logic                  trig_hit;
    t_result               res;

    assign now_t     = TIME_WIDTH'(i_now_ms[NW-1:0]);
    assign el_pulse  = now_t - r_pulse_start;
    assign el_window = now_t - r_window_start;

    always_comb begin
        n_raw          = r_raw;
        n_stable       = r_stable;
        n_raw_time     = r_raw_time;
        n_pulse_start  = r_pulse_start;
        n_window_start = r_window_start;
        n_in_pulse     = r_in_pulse;
        n_window_open  = r_window_open;
        n_count        = r_count;
        n_alarm        = r_alarm;
        n_state        = r_state;
        pulse_set_now  = 1'b0;
        res.decision       = DEC_NONE;
        res.state_changed  = 1'b0;
        res.reported_state = r_state;

        if (i_sense_high != r_raw) begin
            n_raw      = i_sense_high;
            n_raw_time = now_t;
        end
        el_raw = now_t - n_raw_time;

        if (CW'(el_raw) >= CW'(i_cfg.hold_ms) && i_sense_high != r_stable) begin
            n_stable = i_sense_high;
            if (i_sense_high) begin
                if (r_in_pulse) begin
                    n_in_pulse = 1'b0;
                    if (!r_alarm && CW'(el_pulse) >= CW'(i_cfg.trigger_ms)) begin
                        res.decision      = DEC_TRIGGERED;
                        res.state_changed = (n_state != ST_TRIGGERED);
                        n_state           = ST_TRIGGERED;
                        n_alarm           = 1'b1;
                        n_window_open     = 1'b0;
                        n_count           = 2'd0;
                    end else if (!r_alarm && CW'(el_pulse) >= CW'(i_cfg.pulse_min_ms)) begin
                        if (n_count != 2'd3) begin
                            n_count = n_count + 2'd1;
                        end
                    end
                end
            end else begin
                if (!r_window_open) begin
                    n_window_open  = 1'b1;
                    n_window_start = now_t;
                    n_count        = 2'd0;
                end
                n_in_pulse    = 1'b1;
                n_pulse_start = now_t;
                pulse_set_now = 1'b1;
            end
        end

        // A pulse that starts on this sample has zero elapsed time.
        trig_hit = pulse_set_now ? (i_cfg.trigger_ms == '0)
                                 : (CW'(el_pulse) >= CW'(i_cfg.trigger_ms));
        if (n_in_pulse && !n_alarm && trig_hit) begin
            res.decision      = DEC_TRIGGERED;
            res.state_changed = (n_state != ST_TRIGGERED);
            n_state           = ST_TRIGGERED;
            n_alarm           = 1'b1;
            n_window_open     = 1'b0;
            n_count           = 2'd0;
        end

        if (n_window_open && !n_in_pulse && !n_alarm &&
            CW'(el_window) > CW'(i_cfg.pulse_window_ms)) begin
            n_window_open = 1'b0;
            if (n_count[1]) begin
                res.decision      = DEC_DISARMED;
                res.state_changed = (n_state != ST_DISARMED);
                n_state           = ST_DISARMED;
            end else if (n_count == 2'd1) begin
                res.decision      = DEC_ARMED;
                res.state_changed = (n_state != ST_ARMED);
                n_state           = ST_ARMED;
            end
            n_count = 2'd0;
        end

        if (!n_in_pulse && n_alarm) begin
            n_alarm = 1'b0;
        end

        res.reported_state = n_state;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw          <= 1'b1;
            r_stable       <= 1'b1;
            r_raw_time     <= '0;
            r_pulse_start  <= '0;
            r_window_start <= '0;
            r_in_pulse     <= 1'b0;
            r_window_open  <= 1'b0;
            r_count        <= 2'd0;
            r_alarm        <= 1'b0;
            r_state        <= ST_UNKNOWN;
        end else if (i_accept) begin
            r_raw          <= n_raw;
            r_stable       <= n_stable;
            r_raw_time     <= n_raw_time;
            r_pulse_start  <= n_pulse_start;
            r_window_start <= n_window_start;
            r_in_pulse     <= n_in_pulse;
            r_window_open  <= n_window_open;
            r_count        <= n_count;
            r_alarm        <= n_alarm;
            r_state        <= n_state;
        end
    end

endmodule

// File: rtl/siren_pulse_pattern_decoder.sv
// Siren pulse pattern decoder, top level with configuration registers and
// output buffering. An accepted beat's result is registered in the output register
// or skid entry; one beat is accepted every cycle while results are taken.
// An output register plus one skid entry decouple the input from a stalled output.
// Reset is synchronous and active low; it restores the register defaults and
// clears all decoder state. Depends on sppd_pkg and sppd_core.
module siren_pulse_pattern_decoder #(
    parameter int TIME_WIDTH = sppd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_sense_high,
    input  logic [sppd_pkg::NOW_WIDTH-1:0]      i_now_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_decision,
    output logic                                o_state_changed,
    output logic [1:0]                          o_reported_state,
    input  logic                                i_cfg_we,
    input  logic [sppd_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [sppd_pkg::CFG_WIDTH-1:0]      i_cfg_data
);
    import sppd_pkg::*;

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    accept, take;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign take       = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min_ms    <= PULSE_MIN_RST;
            r_cfg.pulse_window_ms <= PULSE_WINDOW_RST;
            r_cfg.trigger_ms      <= TRIGGER_RST;
            r_cfg.hold_ms         <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PULSE_MIN:    r_cfg.pulse_min_ms    <= i_cfg_data;
                CFG_PULSE_WINDOW: r_cfg.pulse_window_ms <= i_cfg_data;
                CFG_TRIGGER:      r_cfg.trigger_ms      <= i_cfg_data;
                CFG_DEBOUNCE:     r_cfg.hold_ms         <= i_cfg_data[DEB_WIDTH-1:0];
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

    sppd_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sense_high (i_sense_high),
        .i_now_ms     (i_now_ms),
        .i_cfg        (r_cfg),
        .o_result     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_out <= core_res;
            end else begin
                r_skid <= core_res;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_decision       = r_out.decision;
    assign o_state_changed  = r_out.state_changed;
    assign o_reported_state = r_out.reported_state;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry is full while the output register is empty.");

    a_change_needs_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_state_changed) |-> (o_decision != DEC_NONE))
        else $error("State change reported without a decision.");

    a_decision_sets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_decision != DEC_NONE) |-> (o_reported_state == o_decision))
        else $error("Reported state does not follow the decision.");

    a_full_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid)
        else $error("Skid entry dropped while the output stays stalled.");

endmodule
